>>> hdl/hlbc_pkg.sv
// Package for the hashed LRU buffer cache tag store.
// Holds operation and status codes shared by the top level and its checker.
`timescale 1ns / 1ps
package hlbc_pkg;
  localparam logic [1:0] MODE_GET     = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_PIN     = 2'd2;
  localparam logic [1:0] MODE_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BUFFER = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam int StampW = 48;
endpackage

>>> hdl/hashed_lru_block_buffer_cache_unit.sv
// Top level of the hashed LRU buffer cache tag store.
// Uses hlbc_pkg for codes; per-buffer tags live in flip-flop arrays.
//
// channel | dir | tdata fields (low bit up)                       | tuser
// s_axis  | in  | mode[1:0] device_id[9:2] block_number[41:10]     | -
//         |     | buffer_index[46:42], zero fill to 48             |
// m_axis  | out | granted_buffer[4:0] was_hit[5] need_read[6]      | -
//         |     | status[8:7] count_after[16:9], zero fill to 24   |
//
// A get first works out the key bucket (reciprocal multiply), then walks the
// buffers one per cycle through one shared compare unit: a hit pass, a local victim
// pass, then one pass per other bucket while no victim is found; the key bucket's
// turn in the steal walk is skipped. Release, pin and unpin go through the pin
// state and then the output state. Input is ready only when idle and the result
// register is empty; a stalled result holds. Reset is asynchronous.
`timescale 1ns / 1ps
module hashed_lru_block_buffer_cache_unit
  import hlbc_pkg::*;
#(
  parameter int BUFFER_COUNT = 32,
  parameter int BUCKET_COUNT = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // mode, device_id, block_number, buffer_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // granted_buffer, was_hit, need_read, status, count_after
);
  localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int BW = 5;
  localparam int SH = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 0;
  // ceil(2^(32+SH) / BUCKET_COUNT): exact quotient for any 32-bit block number
  localparam logic [32:0] RECIP =
    33'(((65'd1 << (32 + SH)) + 65'(BUCKET_COUNT) - 65'd1) / 65'(BUCKET_COUNT));
  localparam logic [IW:0] PTR_END = (IW+1)'(BUFFER_COUNT);

  typedef enum logic [2:0] {
    S_IDLE, S_KEY, S_HIT, S_LOCAL, S_STEAL, S_COMMIT, S_PIN, S_OUT
  } state_e;

  logic [7:0]        tag_dev_q [BUFFER_COUNT];
  logic [31:0]       tag_blk_q [BUFFER_COUNT];
  logic              valid_q   [BUFFER_COUNT];
  logic [7:0]        cnt_q     [BUFFER_COUNT];
  logic [BW-1:0]     bkt_q     [BUFFER_COUNT];
  logic [StampW-1:0] stamp_q   [BUFFER_COUNT];
  logic [StampW-1:0] stamp_ctr_q;

  state_e        state_q;
  logic [1:0]    mode_q;
  logic [7:0]    dev_q;
  logic [31:0]   blk_q;
  logic [4:0]    idx_q;
  logic [BW-1:0] quot_q, scan_b_q;
  logic [IW:0]   ptr_q;
  logic          found_q, moved_q, hit_q;
  logic [IW-1:0] best_q;
  logic [StampW-1:0] best_st_q;
  logic          out_v_q;
  logic [23:0]   out_q;

  logic [64:0]   prod;
  logic [BW-1:0] key_w;
  assign prod  = 65'(blk_q) * 65'(RECIP);
  // the remainder is below 32, so the low bits of blk - q*B are enough
  assign key_w = blk_q[BW-1:0] - BW'(quot_q * BW'(BUCKET_COUNT));

  logic [IW-1:0] p;
  logic          in_b, match, better_hi, better_lo, free_i;
  assign p         = ptr_q[IW-1:0];
  assign in_b      = (bkt_q[p] == ((state_q == S_STEAL) ? scan_b_q : key_w));
  assign match     = in_b && tag_dev_q[p] == dev_q && tag_blk_q[p] == blk_q;
  assign better_hi = !found_q || stamp_q[p] > best_st_q;
  assign better_lo = !found_q || stamp_q[p] < best_st_q;
  assign free_i    = in_b && cnt_q[p] == 8'd0;

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  function automatic logic [23:0] pack(logic [4:0] b, logic h, logic r, logic [1:0] s,
                                       logic [7:0] c);
    return {7'd0, c, s, r, h, b};
  endfunction

  logic [IW-1:0] ix;
  assign ix = IW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_v_q     <= 1'b0;
      out_q       <= '0;
      mode_q      <= '0;
      dev_q       <= '0;
      blk_q       <= '0;
      idx_q       <= '0;
      quot_q      <= '0;
      scan_b_q    <= '0;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      moved_q     <= 1'b0;
      hit_q       <= 1'b0;
      best_q      <= '0;
      best_st_q   <= '0;
      stamp_ctr_q <= StampW'(BUFFER_COUNT);
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        tag_dev_q[i] <= '0;
        tag_blk_q[i] <= '0;
        valid_q[i]   <= 1'b0;
        cnt_q[i]     <= '0;
        bkt_q[i]     <= '0;
        stamp_q[i]   <= StampW'(i);
      end
    end else begin
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            mode_q   <= s_axis_tdata[1:0];
            dev_q    <= s_axis_tdata[9:2];
            blk_q    <= s_axis_tdata[41:10];
            idx_q    <= s_axis_tdata[46:42];
            ptr_q    <= '0;
            found_q  <= 1'b0;
            moved_q  <= 1'b0;
            hit_q    <= 1'b0;
            state_q  <= (s_axis_tdata[1:0] == MODE_GET) ? S_KEY : S_PIN;
          end
        end
        S_KEY: begin
          quot_q  <= prod[32+SH +: BW];
          state_q <= S_HIT;
        end
        S_HIT: begin
          if (ptr_q == PTR_END) begin
            ptr_q   <= '0;
            hit_q   <= found_q;
            state_q <= found_q ? S_COMMIT : S_LOCAL;
          end else begin
            if (match && better_hi) begin
              found_q <= 1'b1; best_q <= p; best_st_q <= stamp_q[p];
            end
            ptr_q <= ptr_q + (IW+1)'(1);
          end
        end
        S_LOCAL, S_STEAL: begin
          if (ptr_q == PTR_END) begin
            ptr_q <= '0;
            if (found_q) begin
              state_q <= S_COMMIT;
            end else begin
              if (state_q == S_LOCAL) scan_b_q <= '0;
              else scan_b_q <= scan_b_q + BW'(1);
              moved_q <= 1'b1;
              if ((state_q == S_LOCAL && BUCKET_COUNT == 1) ||
                  (state_q == S_STEAL && scan_b_q == BW'(BUCKET_COUNT - 1))) begin
                out_q   <= pack(5'd0, 1'b0, 1'b0, ST_NO_BUFFER, 8'd0);
                state_q <= S_OUT;
              end else begin
                state_q <= S_STEAL;
              end
            end
          end else if (state_q == S_STEAL && scan_b_q == key_w) begin
            // skip the key bucket in the steal walk
            ptr_q <= PTR_END;
          end else begin
            ptr_q <= ptr_q + (IW+1)'(1);
            if (free_i && better_lo) begin
              found_q <= 1'b1; best_q <= p; best_st_q <= stamp_q[p];
            end
          end
        end
        S_COMMIT: begin
          state_q <= S_OUT;
          valid_q[best_q] <= 1'b1;
          if (hit_q) begin
            cnt_q[best_q] <= (cnt_q[best_q] == 8'hFF) ? 8'hFF : cnt_q[best_q] + 8'd1;
            out_q <= pack(5'(best_q), 1'b1, !valid_q[best_q], ST_OK,
                          (cnt_q[best_q] == 8'hFF) ? 8'hFF : cnt_q[best_q] + 8'd1);
          end else begin
            tag_dev_q[best_q] <= dev_q;
            tag_blk_q[best_q] <= blk_q;
            cnt_q[best_q]     <= 8'd1;
            out_q <= pack(5'(best_q), 1'b0, 1'b1, ST_OK, 8'd1);
            if (moved_q) begin
              bkt_q[best_q]   <= key_w;
              stamp_q[best_q] <= stamp_ctr_q;
              stamp_ctr_q     <= stamp_ctr_q + StampW'(1);
            end
          end
        end
        S_PIN: begin
          state_q <= S_OUT;
          if ({27'd0, idx_q} >= 32'(BUFFER_COUNT)) begin
            out_q <= pack(idx_q, 1'b0, 1'b0, ST_OK, 8'd0);
          end else if (mode_q == MODE_PIN) begin
            cnt_q[ix] <= (cnt_q[ix] == 8'hFF) ? 8'hFF : cnt_q[ix] + 8'd1;
            out_q <= pack(idx_q, 1'b0, 1'b0, ST_OK,
                          (cnt_q[ix] == 8'hFF) ? 8'hFF : cnt_q[ix] + 8'd1);
          end else if (cnt_q[ix] == 8'd0) begin
            out_q <= pack(idx_q, 1'b0, 1'b0, ST_UNDERFLOW, 8'd0);
          end else begin
            cnt_q[ix] <= cnt_q[ix] - 8'd1;
            if (mode_q == MODE_RELEASE && cnt_q[ix] == 8'd1) begin
              stamp_q[ix] <= stamp_ctr_q;
              stamp_ctr_q <= stamp_ctr_q + StampW'(1);
            end
            out_q <= pack(idx_q, 1'b0, 1'b0, ST_OK, cnt_q[ix] - 8'd1);
          end
        end
        S_OUT: begin
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/hlbc_checker.sv
// Port checker for the hashed LRU buffer cache tag store.
// Depends on hlbc_pkg; bound to the top level below.
`timescale 1ns / 1ps
module hlbc_checker
  import hlbc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted while busy");
  a_nobuf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8:7] == ST_NO_BUFFER |-> m_axis_tdata[6:0] == 7'd0)
    else $error("no_buffer result with flags");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8:7] != 2'd3)
    else $error("bad status code");
endmodule

bind hashed_lru_block_buffer_cache_unit hlbc_checker u_hlbc_checker (.*);

>>> tb/hashed_lru_block_buffer_cache_unit_test.sv
// Testbench for the hashed LRU buffer cache tag store.
// Drives get, release, pin and unpin transfers and checks each result against
// a behavioral copy of the tag store; depends on hlbc_pkg and the top level.
`timescale 1ns / 1ps
module hashed_lru_block_buffer_cache_unit_test;
  import hlbc_pkg::*;

  localparam int NBUF = 32;
  localparam int NBKT = 17;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [7:0] count_after;
    logic [1:0] status;
    logic       need_read;
    logic       was_hit;
    logic [4:0] granted_buffer;
  } cache_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // mode, device_id, block_number, buffer_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // granted_buffer, was_hit, need_read, status, count_after

  hashed_lru_block_buffer_cache_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow tag store
  logic [7:0]  tag_dev[NBUF];
  logic [31:0] tag_blk[NBUF];
  logic        valid_q[NBUF];
  logic [7:0]  refs[NBUF];
  logic [4:0]  bucket[NBUF];
  logic [47:0] stamp[NBUF];
  logic [47:0] next_stamp;

  cache_result_t pending_results[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  failed = 1'b0;
  int  quiet_cycles = 0;
  logic [31:0] recent_blocks[$];

  initial forever #2 clk_i = ~clk_i;

  task automatic clear_shadow();
    for (int i = 0; i < NBUF; i++) begin
      tag_dev[i] = '0;
      tag_blk[i] = '0;
      valid_q[i] = 1'b0;
      refs[i] = '0;
      bucket[i] = '0;
      stamp[i] = 48'(i);
    end
    next_stamp = 48'(NBUF);
  endtask

  function automatic int oldest_free_in(int bk);
    int pick;
    pick = -1;
    for (int i = 0; i < NBUF; i++)
      if (bucket[i] == bk && refs[i] == 0 && (pick < 0 || stamp[i] < stamp[pick]))
        pick = i;
    return pick;
  endfunction

  function automatic cache_result_t predict_cache(logic [1:0] mode, logic [7:0] dev,
                                                  logic [31:0] blk, logic [4:0] idx);
    cache_result_t r;
    int key, hit, victim;
    bit stolen;
    r = '0;
    stolen = 1'b0;
    if (mode == MODE_GET) begin
      key = int'(blk % NBKT);
      hit = -1;
      for (int i = 0; i < NBUF; i++)
        if (bucket[i] == key && tag_dev[i] == dev && tag_blk[i] == blk &&
            (hit < 0 || stamp[i] > stamp[hit]))
          hit = i;
      if (hit >= 0) begin
        r.need_read = ~valid_q[hit];
        if (refs[hit] != 8'hFF) refs[hit]++;
        valid_q[hit] = 1'b1;
        r.granted_buffer = 5'(hit);
        r.was_hit = 1'b1;
        r.count_after = refs[hit];
        return r;
      end
      victim = oldest_free_in(key);
      if (victim < 0) begin
        stolen = 1'b1;
        for (int b = 0; b < NBKT && victim < 0; b++)
          if (b != key) victim = oldest_free_in(b);
      end
      if (victim < 0) begin
        r.status = ST_NO_BUFFER;
        return r;
      end
      tag_dev[victim] = dev;
      tag_blk[victim] = blk;
      refs[victim] = 8'd1;
      valid_q[victim] = 1'b1;
      if (stolen) begin
        bucket[victim] = 5'(key);
        stamp[victim] = next_stamp;
        next_stamp++;
      end
      r.granted_buffer = 5'(victim);
      r.need_read = 1'b1;
      r.count_after = 8'd1;
      return r;
    end
    r.granted_buffer = idx;
    if (mode == MODE_PIN) begin
      if (refs[idx] != 8'hFF) refs[idx]++;
      r.count_after = refs[idx];
    end else if (refs[idx] == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      refs[idx]--;
      if (mode == MODE_RELEASE && refs[idx] == 0) begin
        stamp[idx] = next_stamp;
        next_stamp++;
      end
      r.count_after = refs[idx];
    end
    return r;
  endfunction

  // tvalid stays high after a transfer so items can follow back to back;
  // the caller drops it after the last item
  task automatic send_request(logic [1:0] mode, logic [7:0] dev, logic [31:0] blk,
                              logic [4:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, idx, blk, dev, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_cache(mode, dev, blk, idx));
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    cache_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = cache_result_t'(m_axis_tdata[16:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.granted_buffer != want.granted_buffer) begin
          $display("%0t: granted_buffer expected %0d actual %0d", $time,
                   want.granted_buffer, got.granted_buffer);
          failed = 1'b1;
        end
        if (got.was_hit != want.was_hit) begin
          $display("%0t: was_hit expected %0d actual %0d", $time, want.was_hit, got.was_hit);
          failed = 1'b1;
        end
        if (got.need_read != want.need_read) begin
          $display("%0t: need_read expected %0d actual %0d", $time,
                   want.need_read, got.need_read);
          failed = 1'b1;
        end
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          failed = 1'b1;
        end
        if (got.count_after != want.count_after) begin
          $display("%0t: count_after expected %0d actual %0d", $time,
                   want.count_after, got.count_after);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL hashed_lru_block_buffer_cache_unit");
      $finish;
    end
  end

  task automatic test_reset_state();
    // every buffer matches device 0 block 0 right after reset
    send_request(MODE_GET, 8'd0, 32'd0, 5'd0);
    send_request(MODE_RELEASE, 8'd0, 32'd0, 5'd31);
    send_request(MODE_UNPIN, 8'd0, 32'd0, 5'd3);
  endtask

  task automatic test_field_extremes();
    send_request(MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    send_request(MODE_GET, 8'hA5, 32'h5A5A_5A5A, 5'd0);
    send_request(MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    send_request(MODE_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    send_request(MODE_UNPIN, 8'h00, 32'h0, 5'd31);
    send_request(MODE_RELEASE, 8'h00, 32'h0, 5'd31);
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 260; i++) send_request(MODE_PIN, 8'd0, 32'd0, 5'd7);
    for (int i = 0; i < 256; i++) send_request(MODE_UNPIN, 8'd0, 32'd0, 5'd7);
  endtask

  task automatic test_exhaustion();
    // hold every buffer, then ask once more for no_buffer
    for (int i = 0; i < NBUF; i++) send_request(MODE_GET, 8'd9, 32'(1000 + i), 5'd0);
    send_request(MODE_GET, 8'd9, 32'd5000, 5'd0);
    for (int i = 0; i < NBUF; i++)
      for (int k = 0; k < 3; k++) send_request(MODE_RELEASE, 8'd0, 32'd0, 5'(i));
  endtask

  task automatic test_random_traffic(int n);
    logic [1:0]  mode;
    logic [31:0] blk;
    logic [7:0]  dev;
    for (int i = 0; i < n; i++) begin
      mode = 2'($urandom_range(3));
      if ($urandom_range(9) < 5) mode = MODE_GET;
      dev = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      if (recent_blocks.size() > 0 && $urandom_range(2) != 0)
        blk = recent_blocks[$urandom_range(recent_blocks.size() - 1)];
      else if ($urandom_range(4) == 0)
        blk = $urandom;
      else
        blk = 32'($urandom_range(80));
      if (mode == MODE_GET) begin
        recent_blocks.push_back(blk);
        if (recent_blocks.size() > 40) void'(recent_blocks.pop_front());
      end
      send_request(mode, dev, blk, 5'($urandom));
    end
  endtask

  initial begin
    clear_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 16;
    recv_stall_pct = 48;
    test_reset_state();
    test_field_extremes();
    test_saturation();
    test_exhaustion();
    test_random_traffic(433);
    send_idle_pct = 48;
    recv_stall_pct = 16;
    test_random_traffic(433);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(433);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed)
      $display("PASS hashed_lru_block_buffer_cache_unit");
    else
      $display("FAIL hashed_lru_block_buffer_cache_unit");
    $finish;
  end
endmodule
